[rtl/tklst_pkg.sv]
// ----------------------------------------------------------------------------
// tklst_pkg: shared types and constants of the thread-keyed LRU slot table
// Sizes of the slot row, the link between neighboring cells and the update
// command that the controller broadcasts to every cell.
// ----------------------------------------------------------------------------
package tklst_pkg;

   localparam int ENTRIES = 10;   // slots in the row, 2 to 16
   localparam int SLOT_W  = 4;    // width of a slot index
   localparam int RANK_W  = 4;    // width of a recency rank
   localparam int TAG_W   = 16;   // width of a thread id

   localparam logic [RANK_W-1:0] LRU_RANK = RANK_W'(ENTRIES - 1);

   // Carried from each cell to its right-hand neighbor. All found/slot fields
   // are ORed along the row; at most one cell contributes to each of them.
   typedef struct packed {
      logic              prev_active;   // the cell just before is in use
      logic              hit;
      logic [SLOT_W-1:0] hit_slot;
      logic [RANK_W-1:0] hit_rank;
      logic              free;
      logic [SLOT_W-1:0] free_slot;
      logic [SLOT_W-1:0] victim_slot;
      logic [TAG_W-1:0]  victim_tag;
   } tklst_link_type;

   // Update command, the same for every cell.
   typedef struct packed {
      logic              upd;
      logic [SLOT_W-1:0] sel_slot;
      logic              write_tag;
      logic              age_all;
      logic [RANK_W-1:0] lim_rank;
      logic [TAG_W-1:0]  new_id;
   } tklst_ctl_type;

endpackage

[rtl/tklst_cell.sv]
// ----------------------------------------------------------------------------
// tklst_cell: one slot of the LRU table
// Holds a tag, a recency rank and an in-use flag, matches the broadcast id,
// adds its findings to the link from its left neighbor and applies updates.
// ----------------------------------------------------------------------------
module tklst_cell import tklst_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [SLOT_W-1:0]   cell_idx,
   input  logic [TAG_W-1:0]    look_id,
   input  tklst_ctl_type       ctl,
   input  tklst_link_type      link_i,
   output tklst_link_type      link_o
);

   logic              active_ff;
   logic [RANK_W-1:0] rank_ff;
   logic [TAG_W-1:0]  tag_ff;

   logic match;
   logic free_here;
   logic victim_here;
   logic sel;
   logic age;

   assign match       = active_ff && (tag_ff == look_id);
   // slots fill from index 0 up, so the first unused slot follows a used one
   assign free_here   = !active_ff && link_i.prev_active;
   assign victim_here = active_ff && (rank_ff == LRU_RANK);

   always_comb begin
      link_o.prev_active = active_ff;
      link_o.hit         = link_i.hit | match;
      link_o.hit_slot    = link_i.hit_slot | (match ? cell_idx : '0);
      link_o.hit_rank    = link_i.hit_rank | (match ? rank_ff : '0);
      link_o.free        = link_i.free | free_here;
      link_o.free_slot   = link_i.free_slot | (free_here ? cell_idx : '0);
      link_o.victim_slot = link_i.victim_slot | (victim_here ? cell_idx : '0);
      link_o.victim_tag  = link_i.victim_tag | (victim_here ? tag_ff : '0);
   end

   assign sel = ctl.upd && (ctl.sel_slot == cell_idx);
   assign age = ctl.upd && active_ff && (ctl.age_all || (rank_ff < ctl.lim_rank));

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rank_ff   <= '0;
      end else if (sel) begin
         active_ff <= 1'b1;
         rank_ff   <= '0;
      end else if (age) begin
         rank_ff   <= rank_ff + RANK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (sel && ctl.write_tag) begin
         tag_ff <= ctl.new_id;
      end
   end

endmodule

[rtl/thread_keyed_lru_slot_table.sv]
// ----------------------------------------------------------------------------
// thread_keyed_lru_slot_table: fully associative LRU slot table keyed by id
// A row of slot cells; the request id is broadcast, the cells pass their
// match, free-slot and LRU findings along the row, and the controller
// broadcasts one update per request.
// ----------------------------------------------------------------------------
//   channel   direction   payload
//   req_      in          thread_id
//   rsp_      out         slot, hit, evicted, evicted_id
//
// A request passes through IDLE and LOOK: the accept cycle latches the id, then
// LOOK runs the match/free/LRU chain through the cell row and updates all cells.
// A new request is taken in the cycle after the update, while the response waits.
// A stalled response holds the lookup until the output register frees up.
// Synchronous reset marks every slot unused; no clearing pass is needed.
// ----------------------------------------------------------------------------
module thread_keyed_lru_slot_table import tklst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TAG_W-1:0]  req_thread_id,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic              rsp_hit,
   output logic              rsp_evicted,
   output logic [TAG_W-1:0]  rsp_evicted_id
);

   typedef enum logic {IDLE, LOOK} state_type;

   state_type         state_ff;
   logic [TAG_W-1:0]  id_ff;
   logic              rsp_valid_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              hit_ff, hit_in;
   logic              evicted_ff, evicted_in;
   logic [TAG_W-1:0]  evicted_id_ff, evicted_id_in;

   tklst_link_type links [ENTRIES+1];
   tklst_ctl_type  ctl;
   tklst_link_type tail;
   logic           out_free;
   logic           load;

   assign links[0] = '{prev_active: 1'b1, default: '0};
   assign tail     = links[ENTRIES];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      tklst_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (SLOT_W'(i)),
         .look_id  (id_ff),
         .ctl      (ctl),
         .link_i   (links[i]),
         .link_o   (links[i+1])
      );
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = (state_ff == LOOK) && out_free;

   always_comb begin
      hit_in        = tail.hit;
      evicted_in    = 1'b0;
      evicted_id_in = '0;
      if (tail.hit) begin
         slot_in = tail.hit_slot;
      end else if (tail.free) begin
         slot_in = tail.free_slot;
      end else begin
         slot_in       = tail.victim_slot;
         evicted_in    = 1'b1;
         evicted_id_in = tail.victim_tag;
      end
      ctl.upd       = load;
      ctl.sel_slot  = slot_in;
      ctl.write_tag = !tail.hit;
      ctl.age_all   = !tail.hit;
      ctl.lim_rank  = tail.hit_rank;
      ctl.new_id    = id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  state_ff <= LOOK;
               end
            end
            LOOK: begin
               if (out_free) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == IDLE && req_valid) begin
         id_ff <= req_thread_id;
      end
      if (load) begin
         slot_ff       <= slot_in;
         hit_ff        <= hit_in;
         evicted_ff    <= evicted_in;
         evicted_id_ff <= evicted_id_in;
      end
   end

   assign req_ready      = (state_ff == IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot       = slot_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_evicted    = evicted_ff;
   assign rsp_evicted_id = evicted_id_ff;

`ifndef SYNTH
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("hit response also reports an eviction");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      (load && !tail.hit && !tail.free) |-> tail.prev_active)
      else $error("eviction while the table still has unused slots");

   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == LOOK))
      else $error("accepted request did not start a lookup");
`endif

endmodule

[test/tb_thread_keyed_lru_slot_table.sv]
// ----------------------------------------------------------------------------
// tb_thread_keyed_lru_slot_table: self-checking bench for the LRU slot table
// Drives thread ids through the request channel and checks every response
// against an in-bench model of the slot tags and recency ranks, or against
// a fixed grant. A short stimulus table covers fill, hits, extreme ids and
// evictions; a random part then works a changing pool of ids with stray
// ids mixed in, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_thread_keyed_lru_slot_table;
   import tklst_pkg::*;

   localparam int RANDOM_ITEMS = 1750;
   localparam int PHASE_LEN    = 150;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic              evicted;
      logic [TAG_W-1:0]  evicted_id;
   } slot_grant_type;

   typedef struct packed {
      logic [TAG_W-1:0] id;
      logic             typed;   // grant below is fixed, not predicted
      slot_grant_type   grant;
   } grant_row_type;

   localparam int DIR_ROWS = 20;
   localparam grant_row_type GRANT_TABLE [DIR_ROWS] = '{
      '{16'h0000, 1'b1, '{4'd0, 1'b0, 1'b0, 16'h0000}},
      '{16'hFFFF, 1'b1, '{4'd1, 1'b0, 1'b0, 16'h0000}},
      '{16'h0000, 1'b1, '{4'd0, 1'b1, 1'b0, 16'h0000}},
      '{16'hFFFF, 1'b1, '{4'd1, 1'b1, 1'b0, 16'h0000}},
      '{16'h0001, 1'b1, '{4'd2, 1'b0, 1'b0, 16'h0000}},
      '{16'h0002, 1'b1, '{4'd3, 1'b0, 1'b0, 16'h0000}},
      '{16'h0004, 1'b1, '{4'd4, 1'b0, 1'b0, 16'h0000}},
      '{16'h0008, 1'b1, '{4'd5, 1'b0, 1'b0, 16'h0000}},
      '{16'h0010, 1'b1, '{4'd6, 1'b0, 1'b0, 16'h0000}},
      '{16'h0020, 1'b1, '{4'd7, 1'b0, 1'b0, 16'h0000}},
      '{16'h0040, 1'b1, '{4'd8, 1'b0, 1'b0, 16'h0000}},
      '{16'h8000, 1'b1, '{4'd9, 1'b0, 1'b0, 16'h0000}},
      '{16'h0040, 1'b1, '{4'd8, 1'b1, 1'b0, 16'h0000}},
      '{16'hAAAA, 1'b0, '0},
      '{16'h5555, 1'b0, '0},
      '{16'h0000, 1'b0, '0},
      '{16'h0002, 1'b0, '0},
      '{16'hFFFF, 1'b0, '0},
      '{16'h1234, 1'b0, '0},
      '{16'h0008, 1'b0, '0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [TAG_W-1:0]  req_thread_id = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [SLOT_W-1:0] rsp_slot;
   logic              rsp_hit;
   logic              rsp_evicted;
   logic [TAG_W-1:0]  rsp_evicted_id;

   // model state of the slot row
   logic [TAG_W-1:0]  tag_mem  [ENTRIES];
   logic [RANK_W-1:0] rank_mem [ENTRIES];
   int                slots_used;

   slot_grant_type pending_grants[$];
   int             error_count = 0;
   int             stall_cycles = 0;
   bit             calm = 1'b0;

   thread_keyed_lru_slot_table dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_thread_id  (req_thread_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_slot       (rsp_slot),
      .rsp_hit        (rsp_hit),
      .rsp_evicted    (rsp_evicted),
      .rsp_evicted_id (rsp_evicted_id)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Look up one id in the model, update tags and ranks, return the grant.
   function automatic slot_grant_type predict_grant(input logic [TAG_W-1:0] id);
      slot_grant_type g;
      int             i;
      int             victim;
      int             age_below;
      g = '0;
      for (i = 0; i < slots_used; i++) begin
         if (!g.hit && tag_mem[i] == id) begin
            g.hit  = 1'b1;
            g.slot = SLOT_W'(i);
         end
      end
      if (g.hit) begin
         age_below = rank_mem[g.slot];
      end else begin
         age_below = ENTRIES + 1;
         if (slots_used < ENTRIES) begin
            g.slot = SLOT_W'(slots_used);
            slots_used++;
         end else begin
            victim = 0;
            for (i = 1; i < ENTRIES; i++) begin
               if (rank_mem[i] > rank_mem[victim]) victim = i;
            end
            g.slot       = SLOT_W'(victim);
            g.evicted    = 1'b1;
            g.evicted_id = tag_mem[victim];
         end
         tag_mem[g.slot] = id;
      end
      // age every slot more recent than the one being touched
      for (i = 0; i < slots_used; i++) begin
         if (i != g.slot && rank_mem[i] < age_below) rank_mem[i] = rank_mem[i] + 1'b1;
      end
      rank_mem[g.slot] = '0;
      return g;
   endfunction

   // Offer one id, hold it until taken, then queue its expected grant.
   task automatic send_request(input logic [TAG_W-1:0] id, input bit typed,
                               input slot_grant_type typed_grant);
      slot_grant_type g;
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_thread_id <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      g = predict_grant(id);
      pending_grants.push_back(typed ? typed_grant : g);
   endtask

   task automatic drain_pending();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      slot_grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            report_error($sformatf("unexpected response slot %0d", rsp_slot));
         end else begin
            want = pending_grants.pop_front();
            if (rsp_slot !== want.slot)
               report_error($sformatf("slot %0d, want %0d", rsp_slot, want.slot));
            if (rsp_hit !== want.hit)
               report_error($sformatf("hit %0b, want %0b", rsp_hit, want.hit));
            if (rsp_evicted !== want.evicted)
               report_error($sformatf("evicted %0b, want %0b", rsp_evicted, want.evicted));
            if (rsp_evicted_id !== want.evicted_id)
               report_error($sformatf("evicted_id %h, want %h",
                                      rsp_evicted_id, want.evicted_id));
         end
      end
      rsp_ready <= calm || ($urandom_range(99) >= 7);
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      logic [TAG_W-1:0] id_pool [ENTRIES + 6];
      int               pool_size;
      int               n;
      int               k;
      logic [TAG_W-1:0] id;

      for (k = 0; k < ENTRIES; k++) begin
         tag_mem[k]  = '0;
         rank_mem[k] = '0;
      end
      slots_used = 0;
      pool_size  = ENTRIES;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIR_ROWS; n++)
         send_request(GRANT_TABLE[n].id, GRANT_TABLE[n].typed, GRANT_TABLE[n].grant);
      drain_pending();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 700 && n < 1000);
         if (n % PHASE_LEN == 0) begin
            // new working set: smaller than, equal to or larger than the row
            case ($urandom_range(3))
               0: pool_size = ENTRIES - 2;
               1: pool_size = ENTRIES;
               2: pool_size = ENTRIES + 1;
               default: pool_size = ENTRIES + 6;
            endcase
            for (k = 0; k < ENTRIES + 6; k++) id_pool[k] = TAG_W'($urandom);
         end
         if (n > 0 && n % 400 == 0) drain_pending();
         if ($urandom_range(99) < 85) id = id_pool[$urandom_range(pool_size - 1)];
         else id = TAG_W'($urandom);
         send_request(id, 1'b0, '0);
      end
      calm = 1'b0;
      drain_pending();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
rtl/tklst_pkg.sv
rtl/tklst_cell.sv
rtl/thread_keyed_lru_slot_table.sv
test/tb_thread_keyed_lru_slot_table.sv
